/* hdl/hsl_to_rgb_pixel_top_defines.svh */
// assertion macros for the hsl to rgb pixel converter
// used by hsl_to_rgb_pixel_top, expects clk_i and rst_ni in scope
`ifndef HSL_TO_RGB_PIXEL_TOP_DEFINES_SVH
`define HSL_TO_RGB_PIXEL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define H2R_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define H2R_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/h2r_pkg.sv */
// shared types, constants and tables of the hsl to rgb pixel converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;  // unsigned fraction 0..1
  localparam int SW        = FRAC_BITS + 3;  // signed working width
  localparam int ONE_INT   = 1 << FRAC_BITS;

  localparam logic [FX_W-1:0] FX_ONE        = FX_W'(ONE_INT);
  localparam logic [FX_W-1:0] FX_HALF       = FX_W'(ONE_INT / 2);
  localparam logic [FX_W-1:0] FX_THIRD      = FX_W'((ONE_INT + 1) / 3);
  localparam logic [FX_W-1:0] FX_TWO_THIRDS = FX_W'((2 * ONE_INT + 1) / 3);

  // pipeline depth
  localparam int NUM_STAGES = 7;

  // which colour channel a lane produces
  typedef enum logic [1:0] {
    CHAN_RED,
    CHAN_GREEN,
    CHAN_BLUE
  } chan_e;

  // stage load strobes from the top level
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } pipe_ctl_t;

  // shared values after the front end
  typedef struct packed {
    logic signed [SW-1:0] v1;
    logic signed [SW-1:0] v2;
    logic signed [SW-1:0] d;
    logic [FX_W-1:0]      h;
    logic [FX_W-1:0]      l;
    logic                 sat_zero;
  } chroma_t;

  // code to fraction, round to nearest of code/255
  typedef logic [FX_W-1:0] norm_tab_t [256];

  function automatic norm_tab_t build_norm_tab();
    norm_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = FX_W'((longint'(i) * longint'(ONE_INT) + 127) / 255);
    end
    return tab;
  endfunction

  localparam norm_tab_t NORM_TAB = build_norm_tab();

endpackage

`default_nettype wire

/* hdl/hsl_to_rgb_pixel_top.sv */
// hsl to rgb pixel converter, top level with stream ports and stage control
// depends on h2r_pkg, h2r_front, h2r_chan and hsl_to_rgb_pixel_top_defines.svh
//
// Usage: one hsl pixel per item enters on the s_axis channel and one rgb
// pixel per item leaves on the m_axis channel, in the same order.
// Input tdata holds hue, saturation and lightness, output tdata holds red,
// green and blue, eight bits each from the lowest bit up.
// Pipeline: seven register stages; the result shows on m_axis once the item
// has passed through all of them.
// Throughput: one item per cycle while the receiver takes results; the
// figure is set by the seven-stage pipeline, whose deepest stage holds one
// 19 by 20 bit multiplier per colour lane.
// Each stage carries a valid bit and loads only when it is empty or the
// stage after it is empty or moving, so bubbles close up and items are
// accepted while a finished result still waits in the output register.
// When the receiver stalls the pipeline fills, then s_axis_tready falls;
// nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is then empty and ready.
`timescale 1ns / 1ps
`default_nettype none

`include "hsl_to_rgb_pixel_top_defines.svh"

module hsl_to_rgb_pixel_top
  import h2r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // hue, saturation, lightness
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // red, green, blue
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] vin;
  pipe_ctl_t             ctl;
  chroma_t               chroma;
  logic [7:0]            red, green, blue;

  // ready chain from the output back, load strobes per stage
  always_comb begin
    rdy[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin = {vld_q[NUM_STAGES-2:0], s_axis_tvalid};
    for (int k = 0; k < NUM_STAGES; k++) begin
      ctl.ld[k] = rdy[k] && vin[k];
      vld_d[k]  = rdy[k] ? vin[k] : vld_q[k];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // shared front end
  h2r_front u_front (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .hue_i        (s_axis_tdata[7:0]),
    .saturation_i (s_axis_tdata[15:8]),
    .lightness_i  (s_axis_tdata[23:16]),
    .chroma_o     (chroma)
  );

  // one lane per colour
  h2r_chan u_red (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .chan_i   (CHAN_RED),
    .chroma_i (chroma),
    .byte_o   (red)
  );

  h2r_chan u_green (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .chan_i   (CHAN_GREEN),
    .chroma_i (chroma),
    .byte_o   (green)
  );

  h2r_chan u_blue (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .chan_i   (CHAN_BLUE),
    .chroma_i (chroma),
    .byte_o   (blue)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = {blue, green, red};

  // an accepted item occupies the first stage next cycle
  `H2R_ASSERT_NXT(a_accept_fills, s_axis_tvalid && s_axis_tready, vld_q[0], "accept not seen")
  // an open output leaves the whole pipeline ready
  `H2R_ASSERT_IMP(a_open_ready, m_axis_tready, s_axis_tready, "input blocked while output open")
  // input back-pressure only comes from a full, stalled pipeline
  `H2R_ASSERT_IMP(a_stall_full, !s_axis_tready, (&vld_q) && !m_axis_tready, "early stall")

endmodule

`default_nettype wire

/* hdl/h2r_front.sv */
// front end: normalise codes, form l*s, then v1, v2 and their difference
// depends on h2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module h2r_front
  import h2r_pkg::*;
(
  input  wire logic      clk_i,
  input  wire pipe_ctl_t ctl_i,
  input  wire logic [7:0] hue_i,
  input  wire logic [7:0] saturation_i,
  input  wire logic [7:0] lightness_i,
  output chroma_t        chroma_o
);

  logic [FX_W-1:0] h1_q, s1_q, l1_q;
  logic            sz1_q;
  logic [FX_W-1:0] h2_q, s2_q, l2_q, ls2_q;
  logic            sz2_q;
  logic [2*FX_W-1:0] ls_prod;
  logic [FX_W-1:0]   ls_d;
  logic signed [SW-1:0] l_s, s_s, ls_s, v1_d, v2_d, d_d;
  chroma_t chroma_q;

  // stage 1: table lookup of the three fractions
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[0]) begin
      h1_q  <= NORM_TAB[hue_i];
      s1_q  <= NORM_TAB[saturation_i];
      l1_q  <= NORM_TAB[lightness_i];
      sz1_q <= (saturation_i == 8'd0);
    end
  end

  // stage 2: rounded product l*s
  always_comb begin
    ls_prod = l1_q * s1_q;
    ls_d    = FX_W'((ls_prod + (2*FX_W)'(FX_HALF)) >> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[1]) begin
      h2_q  <= h1_q;
      s2_q  <= s1_q;
      l2_q  <= l1_q;
      ls2_q <= ls_d;
      sz2_q <= sz1_q;
    end
  end

  // stage 3: v2 by lightness half, then v1 and the spread
  always_comb begin
    l_s  = $signed({2'b00, l2_q});
    s_s  = $signed({2'b00, s2_q});
    ls_s = $signed({2'b00, ls2_q});
    if (l2_q < FX_HALF) begin
      v2_d = l_s + ls_s;
    end else begin
      v2_d = l_s + s_s - ls_s;
    end
    v1_d = (l_s <<< 1) - v2_d;
    d_d  = v2_d - v1_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[2]) begin
      chroma_q.v1       <= v1_d;
      chroma_q.v2       <= v2_d;
      chroma_q.d        <= d_d;
      chroma_q.h        <= h2_q;
      chroma_q.l        <= l2_q;
      chroma_q.sat_zero <= sz2_q;
    end
  end

  assign chroma_o = chroma_q;

endmodule

`default_nettype wire

/* hdl/h2r_chan.sv */
// one colour lane: hue argument, ramp product, channel value, byte scaling
// depends on h2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module h2r_chan
  import h2r_pkg::*;
(
  input  wire logic      clk_i,
  input  wire pipe_ctl_t ctl_i,
  input  wire chan_e     chan_i,
  input  wire chroma_t   chroma_i,
  output logic [7:0]     byte_o
);

  localparam int TW = FRAC_BITS + 5;
  localparam int PW = SW + FX_W + 4;
  localparam int XW = SW + 9;

  localparam logic signed [TW-1:0] ONE_T   = TW'(ONE_INT);
  localparam logic signed [TW-1:0] THIRD_T = $signed({{(TW-FX_W){1'b0}}, FX_THIRD});
  localparam logic signed [TW-1:0] TWO3_T  = $signed({{(TW-FX_W){1'b0}}, FX_TWO_THIRDS});

  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } region_e;

  // stage 4 signals
  logic signed [TW-1:0] t0, t1, t2, t6, t2x, t3x, fall_t;
  region_e              region_d, region4_q, region5_q;
  logic [FX_W-1:0]      factor_d, factor4_q;
  logic signed [SW-1:0] v1_4_q, v2_4_q, d_4_q, v1_5_q, v2_5_q;
  logic [FX_W-1:0]      l4_q, l5_q;
  logic                 sz4_q, sz5_q;
  // stage 5 signals
  logic [FX_W+2:0]      f6;
  logic signed [PW-1:0] prod_d, prod5_q;
  // stage 6 signals
  logic                 pneg;
  logic [PW-1:0]        pmag, pq;
  logic [SW-1:0]        rq, ru;
  logic signed [SW-1:0] c_d, c6_q;
  // stage 7 signals
  logic signed [XW-1:0] cx, x;
  logic                 xneg;
  logic [XW-1:0]        xmag, xq;
  logic [7:0]           byte_d, byte_q;

  // stage 4: offset and wrap the hue, pick the ramp segment
  always_comb begin
    t0 = $signed({{(TW-FX_W){1'b0}}, chroma_i.h});
    case (chan_i)
      CHAN_RED:  t0 = t0 + THIRD_T;
      CHAN_BLUE: t0 = t0 - THIRD_T;
      default:   t0 = t0;
    endcase
    t1     = (t0 < 0) ? t0 + ONE_T : t0;
    t2     = (t1 > ONE_T) ? t1 - ONE_T : t1;
    t6     = (t2 <<< 2) + (t2 <<< 1);
    t2x    = t2 <<< 1;
    t3x    = (t2 <<< 1) + t2;
    fall_t = TWO3_T - t2;
    if (t6 < ONE_T) begin
      region_d = RG_RISE;
      factor_d = t2[FX_W-1:0];
    end else if (t2x < ONE_T) begin
      region_d = RG_HIGH;
      factor_d = '0;
    end else if (t3x < (ONE_T <<< 1)) begin
      region_d = RG_FALL;
      factor_d = fall_t[FX_W-1:0];
    end else begin
      region_d = RG_LOW;
      factor_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[3]) begin
      region4_q <= region_d;
      factor4_q <= factor_d;
      v1_4_q    <= chroma_i.v1;
      v2_4_q    <= chroma_i.v2;
      d_4_q     <= chroma_i.d;
      l4_q      <= chroma_i.l;
      sz4_q     <= chroma_i.sat_zero;
    end
  end

  // stage 5: spread times six times the ramp position
  always_comb begin
    f6     = ({3'b000, factor4_q} << 2) + ({3'b000, factor4_q} << 1);
    prod_d = PW'(d_4_q) * $signed({{(PW-FX_W-3){1'b0}}, f6});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[4]) begin
      prod5_q   <= prod_d;
      region5_q <= region4_q;
      v1_5_q    <= v1_4_q;
      v2_5_q    <= v2_4_q;
      l5_q      <= l4_q;
      sz5_q     <= sz4_q;
    end
  end

  // stage 6: round half away from zero, then select the channel value
  always_comb begin
    pneg = prod5_q[PW-1];
    pmag = pneg ? PW'(-prod5_q) : PW'(prod5_q);
    pq   = (pmag + PW'(FX_HALF)) >> FRAC_BITS;
    rq   = pq[SW-1:0];
    ru   = pneg ? (~rq + SW'(1)) : rq;
    case (region5_q)
      RG_RISE: c_d = v1_5_q + $signed(ru);
      RG_FALL: c_d = v1_5_q + $signed(ru);
      RG_HIGH: c_d = v2_5_q;
      RG_LOW:  c_d = v1_5_q;
      default: c_d = v1_5_q;
    endcase
    if (sz5_q) begin
      c_d = $signed({2'b00, l5_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[5]) begin
      c6_q <= c_d;
    end
  end

  // stage 7: times 255, round and clamp to a byte
  always_comb begin
    cx   = XW'(c6_q);
    x    = (cx <<< 8) - cx;
    xneg = x[XW-1];
    xmag = xneg ? XW'(-x) : XW'(x);
    xq   = (xmag + XW'(FX_HALF)) >> FRAC_BITS;
    if (xneg) begin
      byte_d = 8'd0;
    end else if (xq > XW'(255)) begin
      byte_d = 8'd255;
    end else begin
      byte_d = xq[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[6]) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire
